// ----- hdl/i2c_register_master_core_defines.svh -----
// assertion macros for the i2c register master
`ifndef I2C_REGISTER_MASTER_CORE_DEFINES_SVH
`define I2C_REGISTER_MASTER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define IRM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define IRM_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IRM_ASSERT(label, clk, rst, prop, msg)
`define IRM_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ----- hdl/irm_pkg.sv -----
// shared types and constants for the i2c register master
`timescale 1ns / 1ps
package irm_pkg;
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_START_ERR = 3'd1;
   localparam logic [2:0] ST_ADDR_NACK = 3'd2;
   localparam logic [2:0] ST_DATA_NACK = 3'd3;
   localparam logic [2:0] ST_RADDR_NACK = 3'd4;

   localparam int REQ_W = 40;
   localparam int RSP_W = 24;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] device_address;
      logic [7:0] register_address;
      logic [7:0] byte_count;
      logic [7:0] write_byte;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_release;
      logic       sda_release;
      logic       busy_res;
      logic       write_byte_taken;
      logic       read_valid;
      logic [7:0] read_byte;
      logic       read_last;
      logic       done_res;
      logic [2:0] status;
   } rsp_type;

   function automatic req_type unpack_req(input logic [REQ_W-1:0] d);
      req_type r;
      r.op               = d[1:0];
      r.device_address   = d[9:2];
      r.register_address = d[17:10];
      r.byte_count       = d[25:18];
      r.write_byte       = d[33:26];
      r.sda_in           = d[34];
      return r;
   endfunction

   function automatic logic [RSP_W-1:0] pack_rsp(input rsp_type r);
      return {6'b0, r.status, r.done_res, r.read_last, r.read_byte, r.read_valid,
              r.write_byte_taken, r.busy_res, r.sda_release, r.scl_release};
   endfunction
endpackage

// ----- hdl/irm_front.sv -----
// input stage: accepts items, decodes op and queues them for the sequencer
`timescale 1ns / 1ps
module irm_front import irm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,
   output logic             q_valid,
   input  logic             q_ready,
   output req_type          q_item
);
   // two-entry queue
   req_type    mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   req_type    dec;
   logic       push, pop;

   always_comb begin
      dec = unpack_req(req_tdata);
      // op 3 acts as tick only
      if (dec.op != OP_WRITE && dec.op != OP_READ) dec.op = OP_TICK;
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign push = req_tvalid && req_tready;
   assign q_valid = (cnt_ff != 2'd0);
   assign pop = q_valid && q_ready;
   assign q_item = mem_ff[rp_ff];
   assign wp_in = push ? ~wp_ff : wp_ff;
   assign rp_in = pop ? ~rp_ff : rp_ff;
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= dec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end
endmodule

// ----- hdl/irm_back.sv -----
// bus sequencer: runs one tick per queued item and registers the result
`timescale 1ns / 1ps
`include "i2c_register_master_core_defines.svh"
module irm_back import irm_pkg::*; #(
   parameter int MAX_BURST = 255
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [15:0]      tpd,
   input  logic             q_valid,
   output logic             q_ready,
   input  req_type          q_item,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata
);
   localparam logic [4:0] PH_IDLE = 5'd0, PH_START_A = 5'd1, PH_START_B = 5'd2,
      PH_START_C = 5'd3, PH_TX_LOW = 5'd4, PH_TX_DATA = 5'd5, PH_TX_HIGH = 5'd6,
      PH_ACK_LOW = 5'd7, PH_ACK_REL = 5'd8, PH_ACK_HIGH = 5'd9, PH_RX_LOW = 5'd10,
      PH_RX_HIGH = 5'd11, PH_MACK_LOW = 5'd12, PH_MACK_SET = 5'd13,
      PH_MACK_HIGH = 5'd14, PH_MACK_END = 5'd15, PH_STOP_A = 5'd16,
      PH_STOP_B = 5'd17, PH_STOP_C = 5'd18, PH_STOP_D = 5'd19;
   localparam logic [1:0] SG_DEV = 2'd0, SG_REG = 2'd1, SG_DATA = 2'd2, SG_RADDR = 2'd3;
   localparam logic [7:0] MAX_B = 8'(MAX_BURST);

   logic [4:0]  ph_ff, ph_in;
   logic [15:0] dly_ff, dly_in;
   logic [2:0]  units_ff, units_in;
   logic [3:0]  bits_ff, bits_in;
   logic [7:0]  shf_ff, shf_in, left_ff, left_in, dev_ff, dev_in, reg_ff, reg_in;
   logic        rd_ff, rd_in, rst_ff, rst_in, scl_ff, scl_in, sda_ff, sda_in_nx;
   logic [1:0]  stg_ff, stg_in;
   logic [2:0]  fail_ff, fail_in;
   rsp_type     r;
   logic        ovld_ff;
   logic [RSP_W-1:0] odat_ff;
   logic        step;
   logic [15:0] unit;
   logic [7:0]  shv;

   assign q_ready = !ovld_ff || rsp_tready;
   assign step = q_valid && q_ready;
   assign rsp_tvalid = ovld_ff;
   assign rsp_tdata = odat_ff;
   assign unit = (tpd == 16'd0) ? 16'd1 : tpd;

   function automatic logic [2:0] seg_len(input logic [4:0] p);
      unique case (p)
         PH_TX_HIGH, PH_ACK_HIGH, PH_RX_HIGH: seg_len = 3'd3;
         PH_RX_LOW, PH_STOP_B:                seg_len = 3'd2;
         PH_MACK_HIGH:                        seg_len = 3'd4;
         PH_IDLE:                             seg_len = 3'd0;
         default:                             seg_len = 3'd1;
      endcase
   endfunction

   always_comb begin
      ph_in = ph_ff; dly_in = dly_ff; units_in = units_ff; bits_in = bits_ff;
      shf_in = shf_ff; left_in = left_ff; dev_in = dev_ff; reg_in = reg_ff;
      rd_in = rd_ff; rst_in = rst_ff; scl_in = scl_ff; sda_in_nx = sda_ff;
      stg_in = stg_ff; fail_in = fail_ff;
      r = '0;
      shv = '0;
      if (ph_ff == PH_IDLE) begin
         if (q_item.op == OP_WRITE || q_item.op == OP_READ) begin
            dev_in = q_item.device_address;
            reg_in = q_item.register_address;
            rd_in = (q_item.op == OP_READ);
            left_in = (q_item.byte_count > MAX_B) ? MAX_B : q_item.byte_count;
            rst_in = 1'b0; fail_in = ST_OK; bits_in = '0;
            ph_in = PH_START_A;
         end
      end else if (dly_ff + 16'd1 >= unit) begin
         dly_in = '0;
         units_in = units_ff - 3'd1;
         if (units_ff <= 3'd1) begin
            units_in = 3'd0;
            unique case (ph_ff)
               PH_START_A: ph_in = (!rst_ff && !q_item.sda_in) ? PH_IDLE : PH_START_B;
               PH_START_B: ph_in = (!rst_ff && q_item.sda_in) ? PH_IDLE : PH_START_C;
               PH_START_C: begin
                  bits_in = '0; ph_in = PH_TX_LOW;
                  if (rst_ff) begin
                     rst_in = 1'b0; shf_in = dev_ff + 8'd1; stg_in = SG_RADDR;
                  end else begin
                     shf_in = dev_ff; stg_in = SG_DEV;
                  end
               end
               PH_TX_LOW: ph_in = PH_TX_DATA;
               PH_TX_DATA: ph_in = PH_TX_HIGH;
               PH_TX_HIGH: begin
                  shf_in = {shf_ff[6:0], 1'b0};
                  bits_in = bits_ff + 4'd1;
                  ph_in = (bits_ff >= 4'd7) ? PH_ACK_LOW : PH_TX_LOW;
               end
               PH_ACK_LOW: ph_in = PH_ACK_REL;
               PH_ACK_REL: ph_in = PH_ACK_HIGH;
               PH_ACK_HIGH: begin
                  bits_in = '0;
                  unique case (stg_ff)
                     SG_DEV: if (q_item.sda_in) begin
                        fail_in = ST_ADDR_NACK; ph_in = PH_STOP_A;
                     end else begin
                        shf_in = reg_ff; stg_in = SG_REG; ph_in = PH_TX_LOW;
                     end
                     SG_RADDR: if (q_item.sda_in) begin
                        fail_in = ST_RADDR_NACK; ph_in = PH_STOP_A;
                     end else if (left_ff != 8'd0) begin
                        shf_in = '0; ph_in = PH_RX_LOW;
                     end else begin
                        fail_in = ST_OK; ph_in = PH_STOP_A;
                     end
                     default: if (stg_ff == SG_REG && rd_ff) begin
                        rst_in = 1'b1; fail_in = ST_OK; ph_in = PH_STOP_A;
                     end else if (stg_ff == SG_DATA && q_item.sda_in) begin
                        fail_in = ST_DATA_NACK; ph_in = PH_STOP_A;
                     end else if (left_ff != 8'd0) begin
                        left_in = left_ff - 8'd1; r.write_byte_taken = 1'b1;
                        shf_in = q_item.write_byte; stg_in = SG_DATA; ph_in = PH_TX_LOW;
                     end else begin
                        fail_in = ST_OK; ph_in = PH_STOP_A;
                     end
                  endcase
               end
               PH_RX_LOW: ph_in = PH_RX_HIGH;
               PH_RX_HIGH: begin
                  shv = {shf_ff[6:0], q_item.sda_in};
                  shf_in = shv;
                  bits_in = bits_ff + 4'd1;
                  if (bits_ff >= 4'd7) begin
                     r.read_valid = 1'b1; r.read_byte = shv;
                     r.read_last = (left_ff <= 8'd1);
                     if (left_ff != 8'd0) left_in = left_ff - 8'd1;
                     ph_in = PH_MACK_LOW;
                  end else ph_in = PH_RX_LOW;
               end
               PH_MACK_LOW: ph_in = PH_MACK_SET;
               PH_MACK_SET: ph_in = PH_MACK_HIGH;
               PH_MACK_HIGH: ph_in = PH_MACK_END;
               PH_MACK_END: if (left_ff != 8'd0) begin
                  shf_in = '0; bits_in = '0; ph_in = PH_RX_LOW;
               end else begin
                  fail_in = ST_OK; ph_in = PH_STOP_A;
               end
               PH_STOP_A: ph_in = PH_STOP_B;
               PH_STOP_B: ph_in = PH_STOP_C;
               PH_STOP_C: ph_in = PH_STOP_D;
               PH_STOP_D: ph_in = rst_ff ? PH_START_A : PH_IDLE;
               default: ph_in = PH_IDLE;
            endcase
            // finishing: start failure or end of stop
            if (ph_in == PH_IDLE) begin
               r.done_res = 1'b1;
               r.status = (ph_ff == PH_STOP_D) ? fail_ff :
                          ((ph_ff == PH_START_A || ph_ff == PH_START_B) ?
                           ST_START_ERR : ST_OK);
            end
         end
      end else begin
         dly_in = dly_ff + 16'd1;
      end
      // segment entry: reload timers and set line levels
      if (ph_in != ph_ff || (ph_in != PH_IDLE && units_ff <= 3'd1 && dly_in == 16'd0
                             && ph_ff != PH_IDLE)) begin
         dly_in = '0;
         units_in = seg_len(ph_in);
         unique case (ph_in)
            PH_START_A: begin scl_in = 1'b1; sda_in_nx = 1'b1; end
            PH_START_B, PH_STOP_B: sda_in_nx = 1'b0;
            PH_START_C, PH_TX_LOW, PH_ACK_LOW, PH_MACK_LOW, PH_MACK_END, PH_STOP_A:
               scl_in = 1'b0;
            PH_TX_DATA: sda_in_nx = shf_in[7];
            PH_TX_HIGH, PH_ACK_HIGH, PH_RX_HIGH, PH_MACK_HIGH, PH_STOP_C: scl_in = 1'b1;
            PH_ACK_REL, PH_STOP_D: sda_in_nx = 1'b1;
            PH_RX_LOW: begin scl_in = 1'b0; sda_in_nx = 1'b1; end
            PH_MACK_SET: sda_in_nx = (left_in == 8'd0);
            default: ;
         endcase
      end
      r.scl_release = scl_in;
      r.sda_release = sda_in_nx;
      r.busy_res = (ph_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= PH_IDLE; dly_ff <= '0; units_ff <= '0; bits_ff <= '0;
         shf_ff <= '0; left_ff <= '0; dev_ff <= '0; reg_ff <= '0; rd_ff <= 1'b0;
         rst_ff <= 1'b0; scl_ff <= 1'b1; sda_ff <= 1'b1; stg_ff <= SG_DEV;
         fail_ff <= ST_OK; ovld_ff <= 1'b0;
      end else begin
         if (step) begin
            ph_ff <= ph_in; dly_ff <= dly_in; units_ff <= units_in; bits_ff <= bits_in;
            shf_ff <= shf_in; left_ff <= left_in; dev_ff <= dev_in; reg_ff <= reg_in;
            rd_ff <= rd_in; rst_ff <= rst_in; scl_ff <= scl_in; sda_ff <= sda_in_nx;
            stg_ff <= stg_in; fail_ff <= fail_in;
         end
         if (q_ready) ovld_ff <= q_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (step) odat_ff <= pack_rsp(r);
   end

   `IRM_ASSERT(a_idle_no_units, clock, reset, (ph_ff == PH_IDLE) |-> (dly_ff == 16'd0), "idle with delay running")
   `IRM_ASSERT(a_bits_range, clock, reset, (bits_ff <= 4'd8), "bit count out of range")
   `IRM_ASSERT(a_units_range, clock, reset, (ph_ff != PH_IDLE) |-> (units_ff != 3'd0 && units_ff <= 3'd4), "segment length bad")
   `IRM_ASSERT(a_out_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)), "stalled item changed")
endmodule

// ----- hdl/i2c_register_master_core.sv -----
// i2c register master top level
// path: each accepted item passes the input queue, then the sequencer, whose result is held in the output register
// throughput: one item per cycle while results are taken; the sequencer steps once per item
// the two-entry input queue lets input and output stall independently
// reset: synchronous, active high; bus lines released, unit length 10
`timescale 1ns / 1ps
module i2c_register_master_core import irm_pkg::*; #(
   parameter int MAX_BURST = 255
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [15:0]      csr_data,     // ticks_per_delay
   input  logic             req_tvalid,
   output logic             req_tready,
   // op, device_address, register_address, byte_count, write_byte, sda_in
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // scl_release, sda_release, busy_res, write_byte_taken, read_valid,
   // read_byte, read_last, done_res, status
   output logic [RSP_W-1:0] rsp_tdata
);
   logic [15:0] tpd_ff;
   logic        q_valid, q_ready;
   req_type     q_item;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) tpd_ff <= 16'd10;
      else if (csr_valid) tpd_ff <= csr_data;
   end

   irm_front u_front (.clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .q_valid, .q_ready, .q_item);

   irm_back #(.MAX_BURST(MAX_BURST)) u_back (.clock, .reset, .tpd(tpd_ff),
      .q_valid, .q_ready, .q_item, .rsp_tvalid, .rsp_tready, .rsp_tdata);
endmodule

// ----- dv/i2c_register_master_core_tb.sv -----
// testbench for the i2c register master core: a tick-level bus predictor and a slave stimulus
`timescale 1ns / 1ps
module i2c_register_master_core_tb;
   import irm_pkg::*;

   localparam int LIMIT = 200000;

   typedef enum int {
      P_IDLE, P_START_A, P_START_B, P_START_C, P_TX_LOW, P_TX_DATA, P_TX_HIGH,
      P_ACK_LOW, P_ACK_REL, P_ACK_HIGH, P_RX_LOW, P_RX_HIGH, P_MACK_LOW,
      P_MACK_SET, P_MACK_HIGH, P_MACK_END, P_STOP_A, P_STOP_B, P_STOP_C, P_STOP_D
   } bus_phase_e;
   typedef enum int {STG_DEV, STG_REG, STG_DATA, STG_RADDR} byte_stage_e;
   typedef enum int {
      M_GOOD, M_FAIL_A, M_FAIL_B, M_NACK_DEV, M_NACK_REG, M_NACK_DATA, M_NACK_RADDR
   } slave_mode_e;

   class bus_scoreboard;
      int unsigned ticks_per_unit = 10;
      bus_phase_e  phase = P_IDLE;
      byte_stage_e stage = STG_DEV;
      int unsigned dcount, units, bitc, left, fcode;
      logic [7:0]  shft, sdev, sreg;
      bit          isrd, restart, scl = 1, sda = 1;
      rsp_type     exp_q[$];
      rsp_type     cur;
      int          errors;

      function int unsigned seg_len(bus_phase_e p);
         case (p)
            P_TX_HIGH, P_ACK_HIGH, P_RX_HIGH: return 3;
            P_RX_LOW, P_STOP_B: return 2;
            P_MACK_HIGH: return 4;
            P_IDLE: return 0;
            default: return 1;
         endcase
      endfunction

      function void enter(bus_phase_e p);
         phase = p;
         dcount = 0;
         units = seg_len(p);
         case (p)
            P_START_A: begin scl = 1; sda = 1; end
            P_START_B, P_STOP_B: sda = 0;
            P_START_C, P_TX_LOW, P_ACK_LOW, P_MACK_LOW, P_MACK_END, P_STOP_A: scl = 0;
            P_TX_DATA: sda = shft[7];
            P_TX_HIGH, P_ACK_HIGH, P_RX_HIGH, P_MACK_HIGH, P_STOP_C: scl = 1;
            P_ACK_REL, P_STOP_D: sda = 1;
            P_RX_LOW: begin scl = 0; sda = 1; end
            P_MACK_SET: sda = (left == 0);
            default: ;
         endcase
      endfunction

      function void finish(int unsigned code);
         cur.done_res = 1;
         cur.status = code[2:0];
         phase = P_IDLE;
         dcount = 0;
         units = 0;
      endfunction

      function void stop_with(int unsigned code);
         fcode = code;
         enter(P_STOP_A);
      endfunction

      function void send_byte(logic [7:0] v, byte_stage_e s);
         shft = v;
         bitc = 0;
         stage = s;
         enter(P_TX_LOW);
      endfunction

      function void start_rx();
         shft = 0;
         bitc = 0;
         enter(P_RX_LOW);
      endfunction

      function void next_data(logic [7:0] wb);
         if (left > 0) begin
            left--;
            cur.write_byte_taken = 1;
            send_byte(wb, STG_DATA);
         end else stop_with(ST_OK);
      endfunction

      function void segment_end(bit s, logic [7:0] wb);
         case (phase)
            P_START_A: if (!restart && !s) finish(ST_START_ERR); else enter(P_START_B);
            P_START_B: if (!restart && s) finish(ST_START_ERR); else enter(P_START_C);
            P_START_C: begin
               if (restart) begin
                  restart = 0;
                  send_byte(sdev + 8'd1, STG_RADDR);
               end else send_byte(sdev, STG_DEV);
            end
            P_TX_LOW: enter(P_TX_DATA);
            P_TX_DATA: enter(P_TX_HIGH);
            P_TX_HIGH: begin
               shft = shft << 1;
               bitc++;
               enter(bitc >= 8 ? P_ACK_LOW : P_TX_LOW);
            end
            P_ACK_LOW: enter(P_ACK_REL);
            P_ACK_REL: enter(P_ACK_HIGH);
            P_ACK_HIGH: begin
               case (stage)
                  STG_DEV: if (s) stop_with(ST_ADDR_NACK); else send_byte(sreg, STG_REG);
                  STG_REG: begin
                     if (isrd) begin
                        restart = 1;
                        stop_with(ST_OK);
                     end else next_data(wb);
                  end
                  STG_DATA: if (s) stop_with(ST_DATA_NACK); else next_data(wb);
                  default: begin
                     if (s) stop_with(ST_RADDR_NACK);
                     else if (left > 0) start_rx();
                     else stop_with(ST_OK);
                  end
               endcase
            end
            P_RX_LOW: enter(P_RX_HIGH);
            P_RX_HIGH: begin
               shft = {shft[6:0], s};
               bitc++;
               if (bitc >= 8) begin
                  cur.read_valid = 1;
                  cur.read_byte = shft;
                  cur.read_last = (left <= 1);
                  if (left > 0) left--;
                  enter(P_MACK_LOW);
               end else enter(P_RX_LOW);
            end
            P_MACK_LOW: enter(P_MACK_SET);
            P_MACK_SET: enter(P_MACK_HIGH);
            P_MACK_HIGH: enter(P_MACK_END);
            P_MACK_END: if (left > 0) start_rx(); else stop_with(ST_OK);
            P_STOP_A: enter(P_STOP_B);
            P_STOP_B: enter(P_STOP_C);
            P_STOP_C: enter(P_STOP_D);
            P_STOP_D: if (restart) enter(P_START_A); else finish(fcode);
            default: finish(ST_OK);
         endcase
      endfunction

      // one accepted item is one bus tick
      function void note(req_type r);
         int unsigned unit;
         unit = (ticks_per_unit == 0) ? 1 : ticks_per_unit;
         cur = '0;
         if (phase == P_IDLE) begin
            if (r.op == OP_WRITE || r.op == OP_READ) begin
               sdev = r.device_address;
               sreg = r.register_address;
               isrd = (r.op == OP_READ);
               left = r.byte_count;
               restart = 0;
               fcode = 0;
               bitc = 0;
               enter(P_START_A);
            end
         end else begin
            dcount++;
            if (dcount >= unit) begin
               dcount = 0;
               if (units > 0) units--;
               if (units == 0) segment_end(r.sda_in, r.write_byte);
            end
         end
         cur.scl_release = scl;
         cur.sda_release = sda;
         cur.busy_res = (phase != P_IDLE);
         exp_q.push_back(cur);
      endfunction

      function void cmp(string name, int unsigned e, int unsigned a);
         if (e != a) begin
            $error("%s: expected %0d, got %0d", name, e, a);
            errors++;
         end
      endfunction

      function void check(rsp_type a);
         rsp_type e;
         if (exp_q.size() == 0) begin
            $error("result item with nothing expected");
            errors++;
            return;
         end
         e = exp_q.pop_front();
         cmp("scl_release", e.scl_release, a.scl_release);
         cmp("sda_release", e.sda_release, a.sda_release);
         cmp("busy_res", e.busy_res, a.busy_res);
         cmp("write_byte_taken", e.write_byte_taken, a.write_byte_taken);
         cmp("read_valid", e.read_valid, a.read_valid);
         cmp("read_byte", e.read_byte, a.read_byte);
         cmp("read_last", e.read_last, a.read_last);
         cmp("done_res", e.done_res, a.done_res);
         cmp("status", e.status, a.status);
      endfunction

      // sda level a slave in the given mode would present on the next tick
      function bit slave_sda(slave_mode_e m);
         case (phase)
            P_START_A: return restart ? bit'($urandom) : (m != M_FAIL_A);
            P_START_B: return restart ? bit'($urandom) : (m == M_FAIL_B);
            P_ACK_HIGH: begin
               case (stage)
                  STG_DEV: return m == M_NACK_DEV;
                  STG_REG: return (m == M_NACK_REG) ? 1'b1 : bit'($urandom);
                  STG_DATA: return m == M_NACK_DATA;
                  default: return m == M_NACK_RADDR;
               endcase
            end
            default: return bit'($urandom);
         endcase
      endfunction
   endclass

   logic              clock = 0;
   logic              reset = 1;
   logic              csr_valid = 0;
   logic              csr_ready;
   logic [15:0]       csr_data = '0;
   logic              req_tvalid = 0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 0;
   logic [RSP_W-1:0]  rsp_tdata;

   bus_scoreboard sb = new();
   int unsigned   cycles;
   int unsigned   send_idle_pct;
   int unsigned   recv_stall_pct;
   int unsigned   hold_req;
   int unsigned   hold_left;
   int unsigned   items;

   i2c_register_master_core DUT (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("i2c_register_master_core_tb: errors");
         $finish;
      end
   end

   // result side: check, then decide ready for the next edge
   always @(posedge clock) begin
      logic [23:0] w;
      rsp_type     r;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            w = 24'(rsp_tdata);
            r.scl_release = w[0];
            r.sda_release = w[1];
            r.busy_res = w[2];
            r.write_byte_taken = w[3];
            r.read_valid = w[4];
            r.read_byte = w[12:5];
            r.read_last = w[13];
            r.done_res = w[14];
            r.status = w[17:15];
            sb.check(r);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 0;
         end else if (hold_req != 0) begin
            hold_req = 0;
            hold_left = 300;
            rsp_tready <= 0;
         end else rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic send_item(req_type r);
      req_tdata <= {5'b0, r.sda_in, r.write_byte, r.byte_count, r.register_address,
                    r.device_address, r.op};
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
      sb.note(r);
      items++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // one tick with random content; a request op is only sent while busy
   task automatic tick(slave_mode_e m);
      req_type r;
      r = req_type'({$urandom, $urandom});
      if (sb.phase == P_IDLE) r.op = ($urandom_range(1) != 0) ? 2'd3 : OP_TICK;
      r.sda_in = sb.slave_sda(m);
      send_item(r);
   endtask

   task automatic run_txn(logic [1:0] op, logic [7:0] dev, logic [7:0] rg,
                          logic [7:0] cnt, slave_mode_e m);
      req_type r;
      r = req_type'({$urandom, $urandom});
      r.op = op;
      r.device_address = dev;
      r.register_address = rg;
      r.byte_count = cnt;
      send_item(r);
      while (sb.phase != P_IDLE) tick(m);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.exp_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_unit(logic [15:0] v);
      csr_data <= v;
      csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      sb.ticks_per_unit = v;
   endtask

   // mostly short transactions so that every outcome shows up in few items
   task automatic random_txn();
      int unsigned pick;
      logic [1:0]  op;
      pick = $urandom_range(9);
      op = ($urandom_range(1) != 0) ? OP_READ : OP_WRITE;
      if (pick < 3) begin
         run_txn(op, 8'($urandom), 8'($urandom), 8'($urandom_range(1, 255)),
                 ($urandom_range(1) != 0) ? M_FAIL_A : M_FAIL_B);
      end else if (pick < 6) begin
         run_txn(op, 8'($urandom), 8'($urandom), 8'($urandom_range(1, 4)), M_NACK_DEV);
      end else if (pick < 8) begin
         run_txn(OP_WRITE, 8'($urandom), 8'($urandom), 8'd0,
                 ($urandom_range(1) != 0) ? M_GOOD : M_NACK_REG);
      end else if (pick == 8) begin
         run_txn(OP_WRITE, 8'($urandom), 8'($urandom), 8'd1,
                 ($urandom_range(1) != 0) ? M_GOOD : M_NACK_DATA);
      end else begin
         run_txn(OP_READ, 8'($urandom), 8'($urandom), 8'd0,
                 ($urandom_range(1) != 0) ? M_GOOD : M_NACK_RADDR);
      end
      repeat ($urandom_range(0, 3)) tick(M_GOOD);
   endtask

   task automatic run_phase(logic [15:0] unit, int unsigned sidle, int unsigned rstall,
                            int unsigned n, bit pressure);
      int unsigned stop_at;
      write_unit(unit);
      send_idle_pct = sidle;
      recv_stall_pct = rstall;
      stop_at = items + n;
      if (pressure) begin
         hold_req = 1;
         // read past the top address with the register ack ignored
         run_txn(OP_READ, 8'hFF, 8'h00, 8'd1, M_NACK_REG);
         drain();
      end
      while (items < stop_at) random_txn();
      drain();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // default unit length straight out of reset, start fails on the second check
      run_txn(OP_WRITE, 8'hA0, 8'h10, 8'd1, M_FAIL_B);
      drain();

      // a zero unit length acts as one tick
      run_phase(16'd0, 0, 0, 30, 0);
      run_phase(16'd1, 60, 0, 30, 0);
      run_phase(16'd1, 0, 60, 30, 0);
      run_phase(16'd1, 25, 25, 0, 1);

      drain();
      if (sb.errors == 0 && sb.exp_q.size() == 0)
         $display("i2c_register_master_core_tb: clean");
      else
         $display("i2c_register_master_core_tb: errors");
      $finish;
   end
endmodule
